// ----- rtl/lh_pkg.sv -----
// ----------------------------------------------------------------------------
// lh_pkg: shared types and constants of the luma histogram
// Item and result layouts, the command passed from front to back, and the
// luma function used to pick a bin.
// ----------------------------------------------------------------------------
package lh_pkg;

  localparam int COUNT_WIDTH = 32;
  localparam int NUM_BINS    = 256;
  localparam int BIN_W       = $clog2(NUM_BINS);
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = $clog2(QDEPTH + 1);

  localparam logic [7:0] COEF_R = 8'd77;
  localparam logic [7:0] COEF_G = 8'd150;
  localparam logic [7:0] COEF_B = 8'd29;
  localparam logic [7:0] LUMA_MAX = 8'd255;

  typedef enum logic [1:0] {
    OP_ADD        = 2'd0,
    OP_READ       = 2'd1,
    OP_READ_CLEAR = 2'd2,
    OP_SPARE      = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    CMD_INC,
    CMD_READ,
    CMD_CLEAR
  } cmd_kind_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] bin_index;
  } item_t;

  typedef struct packed {
    logic [7:0]  luma;
    logic [31:0] bin_count;
  } result_t;

  typedef struct packed {
    cmd_kind_t        kind;
    logic [BIN_W-1:0] addr;
  } cmd_t;

  // Weighted sum fits in 16 bits; the clamp only guards the top bin.
  function automatic logic [7:0] calc_luma(input logic [7:0] r, input logic [7:0] g,
                                           input logic [7:0] b);
    logic [15:0] sum;
    logic [7:0]  hi;
    sum = 16'(r) * 16'(COEF_R) + 16'(g) * 16'(COEF_G) + 16'(b) * 16'(COEF_B);
    hi  = sum[15:8];
    return (hi > LUMA_MAX) ? LUMA_MAX : hi;
  endfunction

endpackage

// ----- rtl/lh_front.sv -----
// ----------------------------------------------------------------------------
// lh_front: item intake and decode
// Takes one item per transfer, turns it into a bin command and hands it to
// the command queue, holding it while the queue is full.
// ----------------------------------------------------------------------------
module lh_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  lh_pkg::item_t item,
  output logic          push,
  output lh_pkg::cmd_t  cmd,
  input  logic          full
);
  import lh_pkg::*;

  logic  cmd_valid;
  cmd_t  cmd_next;
  logic  accept;

  assign busy   = cmd_valid && full;
  assign accept = start && !busy;
  assign push   = cmd_valid && !full;

  always_comb begin
    case (opcode_t'(item.opcode))
      OP_ADD: begin
        cmd_next.kind = CMD_INC;
        cmd_next.addr = calc_luma(item.red, item.green, item.blue);
      end
      OP_READ_CLEAR: begin
        cmd_next.kind = CMD_CLEAR;
        cmd_next.addr = item.bin_index;
      end
      default: begin
        // The spare opcode behaves as a plain read.
        cmd_next.kind = CMD_READ;
        cmd_next.addr = item.bin_index;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (accept) begin
      cmd_valid <= 1'b1;
    end else if (push) begin
      cmd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd <= cmd_next;
    end
  end

endmodule

// ----- rtl/lh_fifo.sv -----
// ----------------------------------------------------------------------------
// lh_fifo: command queue
// A short first-in first-out queue that decouples decode from the count
// store, so that each side can stall on its own.
// ----------------------------------------------------------------------------
module lh_fifo (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  lh_pkg::cmd_t wr_cmd,
  output logic         full,
  input  logic         pop,
  output lh_pkg::cmd_t rd_cmd,
  output logic         empty
);
  import lh_pkg::*;

  cmd_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full   = (count == QCNT_W'(QDEPTH));
  assign empty  = (count == '0);
  assign rd_cmd = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_cmd;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("command queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("command queue read while empty");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("command queue count did not follow a write");

endmodule

// ----- rtl/lh_back.sv -----
// ----------------------------------------------------------------------------
// lh_back: count store and update pipeline
// Reads the addressed bin, applies increment, read or read-and-clear,
// writes it back and registers the result. A one-deep bypass covers a
// command that follows a write to the same bin.
// ----------------------------------------------------------------------------
module lh_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            empty,
  input  lh_pkg::cmd_t    cmd,
  output logic            pop,
  output logic            done,
  output lh_pkg::result_t result
);
  import lh_pkg::*;

  logic [COUNT_WIDTH-1:0] bin_mem [NUM_BINS];
  logic [NUM_BINS-1:0]    bin_valid;

  logic                   s1_valid;
  cmd_t                   s1_cmd;
  logic                   s1_written;
  logic [COUNT_WIDTH-1:0] s1_rdata;

  logic                   wb_valid;
  logic [BIN_W-1:0]       wb_addr;
  logic [COUNT_WIDTH-1:0] wb_data;

  logic [COUNT_WIDTH-1:0] base;
  logic [COUNT_WIDTH-1:0] count_next;
  logic                   wr_en;

  assign pop = !empty;

  always_comb begin
    if (wb_valid && (wb_addr == s1_cmd.addr)) begin
      base = wb_data;
    end else if (s1_written) begin
      base = s1_rdata;
    end else begin
      base = '0;
    end
    case (s1_cmd.kind)
      CMD_INC:   count_next = (&base) ? base : base + 1'b1;
      CMD_CLEAR: count_next = '0;
      default:   count_next = base;
    endcase
    wr_en = s1_valid && (s1_cmd.kind != CMD_READ);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      wb_valid  <= 1'b0;
      done      <= 1'b0;
      bin_valid <= '0;
    end else begin
      s1_valid <= pop;
      wb_valid <= wr_en;
      done     <= s1_valid;
      if (wr_en) begin
        bin_valid[s1_cmd.addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_cmd     <= cmd;
      s1_rdata   <= bin_mem[cmd.addr];
      s1_written <= bin_valid[cmd.addr];
    end
    if (wr_en) begin
      bin_mem[s1_cmd.addr] <= count_next;
    end
    wb_addr          <= s1_cmd.addr;
    wb_data          <= count_next;
    result.luma      <= s1_cmd.addr;
    result.bin_count <= 32'((s1_cmd.kind == CMD_INC) ? count_next : base);
  end

  a_done_follows_stage: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(s1_valid))
    else $error("result strobe without a command in the update stage");

  a_stage_follows_pop: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> $past(pop))
    else $error("update stage active without a queue read");

  a_written_bin_marked: assert property (@(posedge clk) disable iff (rst)
    wb_valid |-> bin_valid[wb_addr])
    else $error("written bin not marked as holding a count");

endmodule

// ----- rtl/luma_histogram.sv -----
// ----------------------------------------------------------------------------
// luma_histogram: 256-bin luma histogram of an RGB pixel stream
// Each pixel's luma (77R + 150G + 29B) >> 8 selects a bin whose saturating
// count is incremented; bins can also be read, or read and cleared.
// ----------------------------------------------------------------------------
//
//   channel   ports                  handshake
//   -------   --------------------   ----------------------------------------
//   command   start, busy, item      transfer when start is high, busy low
//   result    done, result           one cycle per result, no back-pressure
//
// Every command yields one result, through decode register, queue and update stage.
// The count store has one read and one write port, so the pipeline sustains
// one command per clock, including repeated hits on the same bin.
// Reset clears all bins at once through per-bin valid flags; no sweep is
// needed and commands are taken in the first cycle after reset.
// Busy rises only when the decode register and the four-entry command queue
// are both full; since results cannot be held off, that does not occur
// while commands arrive at most one per clock.
//
module luma_histogram (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  lh_pkg::item_t   item,
  output logic            done,
  output lh_pkg::result_t result
);
  import lh_pkg::*;

  // Decoded command from the front part into the queue.
  logic push;
  cmd_t front_cmd;
  logic full;

  // Queue head toward the count store.
  logic pop;
  cmd_t head_cmd;
  logic empty;

  // The front part computes luma and turns every opcode into a bin command.
  lh_front u_front (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .item  (item),
    .push  (push),
    .cmd   (front_cmd),
    .full  (full)
  );

  // The queue lets decode run ahead of the store update.
  lh_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_cmd (front_cmd),
    .full   (full),
    .pop    (pop),
    .rd_cmd (head_cmd),
    .empty  (empty)
  );

  // The back part owns the count store and produces one result per command.
  lh_back u_back (
    .clk    (clk),
    .rst    (rst),
    .empty  (empty),
    .cmd    (head_cmd),
    .pop    (pop),
    .done   (done),
    .result (result)
  );

endmodule
